### rtl/fua_pkg.sv
// ============================================================================
// FU-A splitter package
// Shared widths, register indexes and header constants of the FU-A splitter.
// ============================================================================
package fua_pkg;

    localparam int LEN_W     = 16;
    localparam int HDR_W     = 8;
    localparam int POS_W     = 2;
    localparam int MPL_W     = 11;
    localparam int RED_W     = 8;
    localparam int BYTES_W   = 11;
    localparam int CFG_IDX_W = 8;

    localparam int DIV_NUM_W = 17;
    localparam int DIV_DEN_W = 11;

    localparam int MAX_FRAGMENTS_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_RED  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_RED   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_RED    = 8'd3;

    localparam logic [MPL_W-1:0] MPL_RESET = 11'd1200;
    localparam logic [MPL_W-1:0] FUA_HDR_BYTES = 11'd2;

    localparam logic [POS_W-1:0] POS_ONLY   = 2'd0;
    localparam logic [POS_W-1:0] POS_FIRST  = 2'd1;
    localparam logic [POS_W-1:0] POS_MIDDLE = 2'd2;

    localparam logic [HDR_W-1:0] FU_START_BIT = 8'h80;
    localparam logic [HDR_W-1:0] FU_END_BIT   = 8'h40;
    localparam logic [HDR_W-1:0] NRI_MASK     = 8'hE0;
    localparam logic [HDR_W-1:0] TYPE_MASK    = 8'h1F;
    localparam logic [HDR_W-1:0] FU_A_TYPE    = 8'd28;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

endpackage

### rtl/fua_divider.sv
// ============================================================================
// FU-A splitter divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by the
// fragment count and the fragment size computations.
// ============================================================================
module fua_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [fua_pkg::DIV_NUM_W-1:0]  dividend,
    input  logic [fua_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                           done,
    output logic [fua_pkg::DIV_NUM_W-1:0]  quotient,
    output logic [fua_pkg::DIV_DEN_W-1:0]  remainder
);

    localparam int NW  = fua_pkg::DIV_NUM_W;
    localparam int DW  = fua_pkg::DIV_DEN_W;
    localparam int CW  = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   rem_shift;
    logic          fits;
    logic [DW:0]   rem_diff;

    assign rem_shift = {rem_reg, quo_reg[NW-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_diff  = rem_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### rtl/fua_fragment_splitter_unit.sv
// ============================================================================
// FU-A fragment splitter
// Splits one NAL unit description into FU-A fragment descriptors of about
// equal size, or gives one error result when no valid split exists.
// ============================================================================
//
// Channel   Direction  Transaction content
// s_*       in         nal_length, nal_header, position
// m_*       out        fragment_bytes, fragment_offset, fua_indicator,
//                      fua_header, last_of_run (tlast), status (tuser)
// cfg_*     in         register index and write data
//
// Without stalls a NAL unit goes from one accepted transaction to the next through the
// check, two passes of the 17-bit serial divider around the fragment count check, a
// checking pass over the sizes, the emitting of its fragments and the idle state. A
// NAL unit that fits in one packet or fails the first check goes straight to its
// single result, one with too many fragments after the count check. Emitting stalls
// while the output register is full and m_tready is low. Reset restores the defaults.
module fua_fragment_splitter_unit #(
    parameter int MAX_FRAGMENTS = fua_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // nal_length [15:0], nal_header [23:16], position [25:24]
    input  logic [31:0]                    s_tdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fragment_bytes [10:0], fragment_offset [26:11], fua_indicator [34:27],
    // fua_header [42:35]
    output logic [47:0]                    m_tdata,
    // status [0]
    output logic                           m_tuser,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fua_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [10:0]                    cfg_data
);

    localparam int LEN_W = fua_pkg::LEN_W;
    localparam int HDR_W = fua_pkg::HDR_W;
    localparam int RED_W = fua_pkg::RED_W;
    localparam int MPL_W = fua_pkg::MPL_W;
    localparam int BW    = fua_pkg::BYTES_W;
    localparam int NW    = fua_pkg::DIV_NUM_W;
    localparam int DW    = fua_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
    localparam int NUM_W = CNT_W + 1;
    localparam int LRG_W = $clog2(MAX_FRAGMENTS);
    localparam int CUR_W = NW + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV1  = 3'd2;
    localparam logic [2:0] ST_NUM   = 3'd3;
    localparam logic [2:0] ST_DIV2  = 3'd4;
    localparam logic [2:0] ST_PASS1 = 3'd5;
    localparam logic [2:0] ST_PASS2 = 3'd6;
    localparam logic [2:0] ST_ONE   = 3'd7;

    logic [2:0]       state_reg;
    logic [MPL_W-1:0] mpl_reg;
    logic [RED_W-1:0] sred_reg;
    logic [RED_W-1:0] fred_reg;
    logic [RED_W-1:0] lred_reg;

    logic [LEN_W-1:0] len_reg;
    logic [HDR_W-1:0] hdr_reg;
    logic [1:0]       pos_reg;
    logic             err_reg;
    logic [NW-1:0]    total_reg;
    logic [NW-1:0]    quot_reg;

    logic [NW-1:0]    per_reg;
    logic [NUM_W-1:0] num_reg;
    logic [LRG_W-1:0] larger_reg;
    logic [NW-1:0]    per0_reg;
    logic [NUM_W-1:0] num0_reg;
    logic [LRG_W-1:0] larger0_reg;
    logic [LEN_W-1:0] remaining_reg;
    logic [CNT_W-1:0] count_reg;
    logic [LEN_W-1:0] offset_reg;

    logic             m_valid_reg;
    logic [47:0]      m_data_reg;
    logic             m_last_reg;
    logic             m_user_reg;

    logic [RED_W-1:0] red_s;
    logic [RED_W-1:0] red_f;
    logic [RED_W-1:0] red_l;
    logic [LEN_W-1:0] payload;
    logic             mpl_ok;
    logic [MPL_W-1:0] capv;
    logic             single_fit;
    logic             cap_bad;
    logic [NW-1:0]    total;
    logic [NW-1:0]    div_dividend;
    logic [NW-1:0]    num_fix;
    logic             num_bad;

    logic             div_start;
    logic [NW-1:0]    div_num;
    logic [DW-1:0]    div_den;
    logic             div_done;
    logic [NW-1:0]    div_q;
    logic [DW-1:0]    div_r;

    logic [NW-1:0]    per_next;
    logic [CUR_W-1:0] cur0;
    logic [CUR_W-1:0] cur1;
    logic [CUR_W-1:0] cur2;
    logic [CUR_W-1:0] cur3;
    logic [CUR_W-1:0] rem_ext;
    logic             step_err;
    logic [LEN_W-1:0] remaining_next;
    logic             out_free;
    logic             out_load;
    logic [HDR_W-1:0] fu_ind;
    logic [HDR_W-1:0] fu_hdr;

    // Register file.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpl_reg  <= fua_pkg::MPL_RESET;
            sred_reg <= '0;
            fred_reg <= '0;
            lred_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                fua_pkg::REG_MAX_PAYLOAD: mpl_reg  <= cfg_data;
                fua_pkg::REG_SINGLE_RED:  sred_reg <= cfg_data[RED_W-1:0];
                fua_pkg::REG_FIRST_RED:   fred_reg <= cfg_data[RED_W-1:0];
                fua_pkg::REG_LAST_RED:    lred_reg <= cfg_data[RED_W-1:0];
                default: ;
            endcase
        end
    end

    // Reductions by position in the frame.
    always_comb begin
        case (pos_reg)
            fua_pkg::POS_ONLY: begin
                red_s = sred_reg;
                red_f = fred_reg;
                red_l = lred_reg;
            end
            fua_pkg::POS_FIRST: begin
                red_s = fred_reg;
                red_f = fred_reg;
                red_l = '0;
            end
            fua_pkg::POS_MIDDLE: begin
                red_s = '0;
                red_f = '0;
                red_l = '0;
            end
            default: begin
                red_s = lred_reg;
                red_f = '0;
                red_l = lred_reg;
            end
        endcase
    end

    assign payload      = len_reg - LEN_W'(1);
    assign mpl_ok       = mpl_reg >= fua_pkg::FUA_HDR_BYTES;
    assign capv         = mpl_reg - fua_pkg::FUA_HDR_BYTES;
    assign single_fit   = mpl_ok &&
                          (NW'(capv) >= (NW'(payload) + NW'(red_s)));
    assign cap_bad      = !mpl_ok || (capv <= MPL_W'(red_f)) || (capv <= MPL_W'(red_l));
    assign total        = NW'(payload) + NW'(red_f) + NW'(red_l);
    assign div_dividend = total + NW'(capv) - NW'(1);

    assign num_fix = (quot_reg == NW'(1)) ? NW'(2) : quot_reg;
    assign num_bad = (NW'(payload) < num_fix) || (num_fix > NW'(MAX_FRAGMENTS));

    assign div_start = ((state_reg == ST_CHECK) && (len_reg >= LEN_W'(2)) &&
                        !single_fit && !cap_bad) ||
                       ((state_reg == ST_NUM) && !num_bad);
    assign div_num   = (state_reg == ST_CHECK) ? div_dividend : total_reg;
    assign div_den   = (state_reg == ST_CHECK) ? capv : DW'(num_fix);

    fua_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // One fragment size step, used by both the checking and emitting passes.
    always_comb begin
        per_next = (num_reg == NUM_W'(larger_reg)) ? per_reg + NW'(1) : per_reg;
        cur0     = CUR_W'(per_next);
        rem_ext  = CUR_W'(remaining_reg);
        if (count_reg == '0) begin
            cur1 = (cur0 > (CUR_W'(red_f) + CUR_W'(1))) ? cur0 - CUR_W'(red_f)
                                                        : CUR_W'(1);
        end else begin
            cur1 = cur0;
        end
        cur2 = (cur1 > rem_ext) ? rem_ext : cur1;
        cur3 = ((num_reg == NUM_W'(2)) && (cur2 == rem_ext)) ? cur2 - CUR_W'(1) : cur2;
        step_err = (count_reg >= CNT_W'(MAX_FRAGMENTS)) || (cur3 == '0) ||
                   (cur3 > CUR_W'((1 << BW) - 1));
        remaining_next = remaining_reg - cur3[LEN_W-1:0];
    end

    assign out_free = !m_valid_reg || m_tready;
    assign out_load = ((state_reg == ST_PASS2) || (state_reg == ST_ONE)) && out_free;
    assign fu_ind   = (hdr_reg & fua_pkg::NRI_MASK) | fua_pkg::FU_A_TYPE;
    assign fu_hdr   = (hdr_reg & fua_pkg::TYPE_MASK) |
                      ((count_reg == '0) ? fua_pkg::FU_START_BIT : '0) |
                      ((remaining_next == '0) ? fua_pkg::FU_END_BIT : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if ((len_reg < LEN_W'(2)) || single_fit || cap_bad) begin
                        state_reg <= ST_ONE;
                    end else begin
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        state_reg <= ST_NUM;
                    end
                end
                ST_NUM: begin
                    state_reg <= num_bad ? ST_ONE : ST_DIV2;
                end
                ST_DIV2: begin
                    if (div_done) begin
                        state_reg <= ST_PASS1;
                    end
                end
                ST_PASS1: begin
                    if (remaining_reg == '0) begin
                        state_reg <= ST_PASS2;
                    end else if (step_err) begin
                        state_reg <= ST_ONE;
                    end
                end
                ST_PASS2: begin
                    if (out_free && (remaining_next == '0)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                len_reg <= s_tdata[15:0];
                hdr_reg <= s_tdata[23:16];
                pos_reg <= s_tdata[25:24];
            end
            ST_CHECK: begin
                err_reg   <= (len_reg < LEN_W'(2)) || (!single_fit && cap_bad);
                total_reg <= total;
            end
            ST_DIV1: begin
                quot_reg <= div_q;
            end
            ST_NUM: begin
                err_reg  <= num_bad;
                num0_reg <= NUM_W'(num_fix);
            end
            ST_DIV2: begin
                per_reg       <= div_q;
                per0_reg      <= div_q;
                larger_reg    <= div_r[LRG_W-1:0];
                larger0_reg   <= div_r[LRG_W-1:0];
                num_reg       <= num0_reg;
                remaining_reg <= payload;
                count_reg     <= '0;
            end
            ST_PASS1: begin
                if (remaining_reg == '0) begin
                    per_reg       <= per0_reg;
                    larger_reg    <= larger0_reg;
                    num_reg       <= num0_reg;
                    remaining_reg <= payload;
                    count_reg     <= '0;
                    offset_reg    <= LEN_W'(1);
                end else begin
                    err_reg       <= step_err;
                    per_reg       <= per_next;
                    num_reg       <= num_reg - NUM_W'(1);
                    remaining_reg <= remaining_next;
                    count_reg     <= count_reg + CNT_W'(1);
                end
            end
            ST_PASS2: begin
                if (out_free) begin
                    m_data_reg <= {5'd0, fu_hdr, fu_ind, offset_reg, cur3[BW-1:0]};
                    m_last_reg <= (remaining_next == '0);
                    m_user_reg <= fua_pkg::STATUS_OK;
                    per_reg       <= per_next;
                    num_reg       <= num_reg - NUM_W'(1);
                    remaining_reg <= remaining_next;
                    count_reg     <= count_reg + CNT_W'(1);
                    offset_reg    <= offset_reg + cur3[LEN_W-1:0];
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    m_last_reg <= 1'b1;
                    if (err_reg) begin
                        m_data_reg <= '0;
                        m_user_reg <= fua_pkg::STATUS_ERR;
                    end else begin
                        m_data_reg <= {5'd0,
                                       (hdr_reg & fua_pkg::TYPE_MASK) |
                                       fua_pkg::FU_START_BIT | fua_pkg::FU_END_BIT,
                                       fu_ind, LEN_W'(1), payload[BW-1:0]};
                        m_user_reg <= fua_pkg::STATUS_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule
